// ===== rtl/gzcp_pkg.sv =====
// Shared types, codes and a helper function of the gzip container parser.
package gzcp_pkg;

  localparam int unsigned TRAILER_BYTES = 8;
  localparam int unsigned TAIL_IDX_W = 3;
  localparam int unsigned FILL_W = 4;
  localparam logic [4:0] MIN_MEMBER = 5'd18;

  localparam logic [7:0] MAGIC0 = 8'h1F;
  localparam logic [7:0] MAGIC1 = 8'h8B;
  localparam logic [7:0] CM_DEFLATE = 8'd8;

  localparam int unsigned FLG_HCRC_BIT = 1;
  localparam int unsigned FLG_EXTRA_BIT = 2;
  localparam int unsigned FLG_NAME_BIT = 3;
  localparam int unsigned FLG_COMMENT_BIT = 4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_METHOD = 3'd3;
  localparam logic [2:0] ST_TRUNC_EXTRA = 3'd4;
  localparam logic [2:0] ST_TRUNC_NAME = 3'd5;
  localparam logic [2:0] ST_TRUNC_COMMENT = 3'd6;
  localparam logic [2:0] ST_TRUNC_DATA = 3'd7;

  localparam logic [2:0] RANK_XLEN = 3'd1;
  localparam logic [2:0] RANK_NAME = 3'd3;
  localparam logic [2:0] RANK_COMMENT = 3'd4;
  localparam logic [2:0] RANK_HCRC = 3'd5;

  typedef enum logic [7:0] {
    PH_FIXED   = 8'b0000_0001,
    PH_XLEN    = 8'b0000_0010,
    PH_EXTRA   = 8'b0000_0100,
    PH_NAME    = 8'b0000_1000,
    PH_COMMENT = 8'b0001_0000,
    PH_HCRC    = 8'b0010_0000,
    PH_DATA    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic        has_byte;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_val;
    logic        has_sum;
    logic [2:0]  status;
    logic [7:0]  flags;
    logic [31:0] mtime;
    logic [31:0] crc;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // First optional field at or after the given rank that the flags call for.
  function automatic phase_e next_field(input logic [7:0] flags, input logic [2:0] from_rank);
    phase_e ph;
    ph = PH_DATA;
    if (from_rank <= RANK_HCRC && flags[FLG_HCRC_BIT]) ph = PH_HCRC;
    if (from_rank <= RANK_COMMENT && flags[FLG_COMMENT_BIT]) ph = PH_COMMENT;
    if (from_rank <= RANK_NAME && flags[FLG_NAME_BIT]) ph = PH_NAME;
    if (from_rank <= RANK_XLEN && flags[FLG_EXTRA_BIT]) ph = PH_XLEN;
    return ph;
  endfunction

endpackage

// ===== rtl/gzcp_front.sv =====
// Front end: accepts bytes, tracks the member layout and builds queue entries.
module gzcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  input  gzcp_pkg::q_status_t q_stat_i,
  output logic              push_o,
  output gzcp_pkg::entry_t  push_data_o
);

  gzcp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [4:0]  total_q, total_d;
  logic [16:0] extra_q, extra_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] mtime_q, mtime_d;
  logic [2:0]  err_q, err_d;
  logic [gzcp_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [7:0]  tail_q [gzcp_pkg::TRAILER_BYTES];
  logic [7:0]  tail_d [gzcp_pkg::TRAILER_BYTES];
  logic        accept;
  logic [2:0]  status;
  gzcp_pkg::entry_t ent;

  assign in_ready_o = !q_stat_i.full;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    hidx_d = hidx_q;
    extra_d = extra_q;
    flags_d = flags_q;
    mtime_d = mtime_q;
    err_d = err_q;
    fill_d = fill_q;
    tail_d = tail_q;
    ent = '0;
    ent.byte_kind = gzcp_pkg::KIND_PAYLOAD;
    total_d = (total_q < gzcp_pkg::MIN_MEMBER) ? total_q + 5'd1 : total_q;

    case (phase_q)
      gzcp_pkg::PH_FIXED: begin
        if ((hidx_q == 4'd0 && data_byte_i != gzcp_pkg::MAGIC0) ||
            (hidx_q == 4'd1 && data_byte_i != gzcp_pkg::MAGIC1)) begin
          if (err_q == gzcp_pkg::ST_OK) err_d = gzcp_pkg::ST_BAD_MAGIC;
          phase_d = gzcp_pkg::PH_ERROR;
        end else if (hidx_q == 4'd2 && data_byte_i != gzcp_pkg::CM_DEFLATE) begin
          if (err_q == gzcp_pkg::ST_OK) err_d = gzcp_pkg::ST_BAD_METHOD;
          phase_d = gzcp_pkg::PH_ERROR;
        end else begin
          case (hidx_q)
            4'd3: flags_d = data_byte_i;
            4'd4: mtime_d[7:0] = data_byte_i;
            4'd5: mtime_d[15:8] = data_byte_i;
            4'd6: mtime_d[23:16] = data_byte_i;
            4'd7: mtime_d[31:24] = data_byte_i;
            default: ;
          endcase
          if (hidx_q >= 4'd9) begin
            hidx_d = 4'd0;
            phase_d = gzcp_pkg::next_field(flags_q, gzcp_pkg::RANK_XLEN);
          end else begin
            hidx_d = hidx_q + 4'd1;
          end
        end
      end
      gzcp_pkg::PH_XLEN: begin
        if (hidx_q == 4'd0) begin
          extra_d = {9'd0, data_byte_i};
          hidx_d = 4'd1;
        end else begin
          extra_d = {1'b0, data_byte_i, extra_q[7:0]};
          hidx_d = 4'd0;
          phase_d = (extra_d != 17'd0) ? gzcp_pkg::PH_EXTRA
                                       : gzcp_pkg::next_field(flags_q, gzcp_pkg::RANK_NAME);
        end
      end
      gzcp_pkg::PH_EXTRA: begin
        extra_d = extra_q - 17'd1;
        if (extra_d == 17'd0) phase_d = gzcp_pkg::next_field(flags_q, gzcp_pkg::RANK_NAME);
      end
      gzcp_pkg::PH_NAME: begin
        if (data_byte_i == 8'd0) begin
          phase_d = gzcp_pkg::next_field(flags_q, gzcp_pkg::RANK_COMMENT);
        end else begin
          ent.has_byte = 1'b1;
          ent.byte_kind = gzcp_pkg::KIND_NAME;
          ent.byte_val = data_byte_i;
        end
      end
      gzcp_pkg::PH_COMMENT: begin
        if (data_byte_i == 8'd0) phase_d = gzcp_pkg::next_field(flags_q, gzcp_pkg::RANK_HCRC);
      end
      gzcp_pkg::PH_HCRC: begin
        if (hidx_q == 4'd0) begin
          hidx_d = 4'd1;
        end else begin
          hidx_d = 4'd0;
          phase_d = gzcp_pkg::PH_DATA;
        end
      end
      gzcp_pkg::PH_DATA: begin
        if (fill_q >= gzcp_pkg::FILL_W'(gzcp_pkg::TRAILER_BYTES)) begin
          ent.has_byte = 1'b1;
          ent.byte_kind = gzcp_pkg::KIND_PAYLOAD;
          ent.byte_val = tail_q[0];
          for (int i = 0; i < gzcp_pkg::TRAILER_BYTES - 1; i++) begin
            tail_d[i] = tail_q[i+1];
          end
          tail_d[gzcp_pkg::TRAILER_BYTES-1] = data_byte_i;
        end else begin
          tail_d[fill_q[gzcp_pkg::TAIL_IDX_W-1:0]] = data_byte_i;
          fill_d = fill_q + 1'b1;
        end
      end
      default: ;
    endcase

    if (total_d < gzcp_pkg::MIN_MEMBER) begin
      status = gzcp_pkg::ST_SHORT;
    end else if (err_d != gzcp_pkg::ST_OK) begin
      status = err_d;
    end else if (phase_d == gzcp_pkg::PH_XLEN || phase_d == gzcp_pkg::PH_EXTRA) begin
      status = gzcp_pkg::ST_TRUNC_EXTRA;
    end else if (phase_d == gzcp_pkg::PH_NAME) begin
      status = gzcp_pkg::ST_TRUNC_NAME;
    end else if (phase_d == gzcp_pkg::PH_COMMENT) begin
      status = gzcp_pkg::ST_TRUNC_COMMENT;
    end else if (phase_d == gzcp_pkg::PH_DATA &&
                 fill_d >= gzcp_pkg::FILL_W'(gzcp_pkg::TRAILER_BYTES)) begin
      status = gzcp_pkg::ST_OK;
    end else begin
      status = gzcp_pkg::ST_TRUNC_DATA;
    end

    ent.has_sum = last_i;
    ent.status = status;
    ent.flags = flags_d;
    ent.mtime = mtime_d;
    if (status == gzcp_pkg::ST_OK) begin
      ent.crc = {tail_d[3], tail_d[2], tail_d[1], tail_d[0]};
      ent.size = {tail_d[7], tail_d[6], tail_d[5], tail_d[4]};
    end

    if (last_i) begin
      phase_d = gzcp_pkg::PH_FIXED;
      hidx_d = 4'd0;
      total_d = 5'd0;
      extra_d = 17'd0;
      flags_d = 8'd0;
      mtime_d = 32'd0;
      err_d = gzcp_pkg::ST_OK;
      fill_d = '0;
    end
  end

  assign push_o = accept && (ent.has_byte || ent.has_sum);
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gzcp_pkg::PH_FIXED;
      hidx_q <= 4'd0;
      total_q <= 5'd0;
      extra_q <= 17'd0;
      flags_q <= 8'd0;
      mtime_q <= 32'd0;
      err_q <= gzcp_pkg::ST_OK;
      fill_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hidx_q <= hidx_d;
      total_q <= total_d;
      extra_q <= extra_d;
      flags_q <= flags_d;
      mtime_q <= mtime_d;
      err_q <= err_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tail_q <= tail_d;
    end
  end

endmodule

// ===== rtl/gzcp_queue.sv =====
// Small queue of result entries between the front end and the back end.
module gzcp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gzcp_pkg::entry_t    push_data_i,
  input  logic                pop_i,
  output gzcp_pkg::entry_t    head_o,
  output gzcp_pkg::q_status_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gzcp_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop = pop_i && !stat_o.empty;
  assign head_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/gzcp_back.sv =====
// Back end: turns queue entries into one or two result beats.
module gzcp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gzcp_pkg::entry_t    head_i,
  input  gzcp_pkg::q_status_t q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          out_byte_o,
  output logic [2:0]          status_o,
  output logic [7:0]          header_flags_o,
  output logic [31:0]         mod_time_o,
  output logic [31:0]         stored_crc_o,
  output logic [31:0]         stored_size_o,
  output logic                run_end_o
);

  logic        valid_q, valid_d;
  logic        byte_done_q, byte_done_d;
  logic        load;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] mtime_q, mtime_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] size_q, size_d;
  logic        run_end_q, run_end_d;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    pop_o = 1'b0;
    byte_done_d = byte_done_q;
    valid_d = valid_q && !out_ready_i;
    kind_d = kind_q;
    byte_d = byte_q;
    status_d = status_q;
    flags_d = flags_q;
    mtime_d = mtime_q;
    crc_d = crc_q;
    size_d = size_q;
    run_end_d = run_end_q;
    if (load && !q_stat_i.empty) begin
      valid_d = 1'b1;
      if (head_i.has_byte && !byte_done_q) begin
        kind_d = head_i.byte_kind;
        byte_d = head_i.byte_val;
        status_d = gzcp_pkg::ST_OK;
        flags_d = 8'd0;
        mtime_d = 32'd0;
        crc_d = 32'd0;
        size_d = 32'd0;
        run_end_d = !head_i.has_sum;
        if (head_i.has_sum) begin
          byte_done_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        kind_d = gzcp_pkg::KIND_SUMMARY;
        byte_d = 8'd0;
        status_d = head_i.status;
        flags_d = head_i.flags;
        mtime_d = head_i.mtime;
        crc_d = head_i.crc;
        size_d = head_i.size;
        run_end_d = 1'b1;
        pop_o = 1'b1;
        byte_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      byte_done_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      byte_done_q <= byte_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    status_q <= status_d;
    flags_q <= flags_d;
    mtime_q <= mtime_d;
    crc_q <= crc_d;
    size_q <= size_d;
    run_end_q <= run_end_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o = kind_q;
  assign out_byte_o = byte_q;
  assign status_o = status_q;
  assign header_flags_o = flags_q;
  assign mod_time_o = mtime_q;
  assign stored_crc_o = crc_q;
  assign stored_size_o = size_q;
  assign run_end_o = run_end_q;

endmodule

// ===== rtl/gzip_container_parser_unit.sv =====
// Top level of the gzip member parser: front end, entry queue and back end.
//
//   Channel | Handshake             | Beat contents
//   --------+-----------------------+----------------------------------------------
//   in      | in_valid_i/in_ready_o | data_byte_i, last_i
//   out     | out_valid_o/out_ready_i | kind_o, out_byte_o, status_o, header_flags_o,
//           |                       | mod_time_o, stored_crc_o, stored_size_o, run_end_o
//
// One input beat is accepted per cycle while the entry queue has room.
// A result is written into the entry queue and then into the back-end output register before it is presented.
// A beat that yields two results holds its queue entry until both have been loaded; the
// queue of QUEUE_DEPTH entries absorbs it, and the input stalls only while the queue is full.
// Reset is asynchronous and active low; it clears the parse state and the queue.
// A stalled output holds its beat while the front end keeps accepting until the queue fills.
module gzip_container_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  header_flags_o,
  output logic [31:0] mod_time_o,
  output logic [31:0] stored_crc_o,
  output logic [31:0] stored_size_o,
  output logic        run_end_o
);

  gzcp_pkg::q_status_t q_stat;
  gzcp_pkg::entry_t    push_data;
  gzcp_pkg::entry_t    head;
  logic                push;
  logic                pop;

  gzcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gzcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  gzcp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .header_flags_o (header_flags_o),
    .mod_time_o     (mod_time_o),
    .stored_crc_o   (stored_crc_o),
    .stored_size_o  (stored_size_o),
    .run_end_o      (run_end_o)
  );

endmodule

// ===== rtl/gzcp_checker.sv =====
// Port-level checks of the gzip member parser and their bind to the top level.
module gzcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  status_o,
  input logic [7:0]  header_flags_o,
  input logic [31:0] mod_time_o,
  input logic [31:0] stored_crc_o,
  input logic [31:0] stored_size_o,
  input logic        run_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(out_byte_o)
      && $stable(status_o) && $stable(run_end_o))
    else $error("Output beat changed while stalled.");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != gzcp_pkg::KIND_SUMMARY |-> status_o == gzcp_pkg::ST_OK
      && header_flags_o == 8'd0 && mod_time_o == 32'd0 && stored_crc_o == 32'd0
      && stored_size_o == 32'd0)
    else $error("Byte beat carries summary fields.");

  a_summary_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == gzcp_pkg::KIND_SUMMARY |-> out_byte_o == 8'd0 && run_end_o)
    else $error("Summary beat is malformed.");

  a_trailer_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gzcp_pkg::ST_OK |-> stored_crc_o == 32'd0
      && stored_size_o == 32'd0)
    else $error("Trailer fields reported with a failing status.");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == gzcp_pkg::KIND_PAYLOAD || kind_o == gzcp_pkg::KIND_NAME
      || kind_o == gzcp_pkg::KIND_SUMMARY)
    else $error("Unknown result kind.");

endmodule

bind gzip_container_parser_unit gzcp_checker u_gzcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .out_byte_o     (out_byte_o),
  .status_o       (status_o),
  .header_flags_o (header_flags_o),
  .mod_time_o     (mod_time_o),
  .stored_crc_o   (stored_crc_o),
  .stored_size_o  (stored_size_o),
  .run_end_o      (run_end_o)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the gzip member parser: directed and random member traffic with a scoreboard.
module tb;

  localparam int FROM_XLEN = 0;
  localparam int FROM_NAME = 1;
  localparam int FROM_COMMENT = 2;
  localparam int FROM_HCRC = 3;

  localparam int SPOIL_NONE = 0;
  localparam int SPOIL_MAGIC0 = 1;
  localparam int SPOIL_MAGIC1 = 2;
  localparam int SPOIL_METHOD = 3;

  localparam int HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BEATS = 380;
  localparam int PRESSURE_BEATS = 140;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [2:0]  status;
    logic [7:0]  flags;
    logic [31:0] mtime;
    logic [31:0] crc;
    logic [31:0] size;
    logic        run_end;
  } gz_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  status_o;
  logic [7:0]  header_flags_o;
  logic [31:0] mod_time_o;
  logic [31:0] stored_crc_o;
  logic [31:0] stored_size_o;
  logic        run_end_o;

  in_beat_t   member_bytes_q[$];
  gz_result_t expected_beats[$];

  int   items_queued = 0;
  int   beats_taken = 0;
  int   mismatches = 0;
  int   sender_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_ticket = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  logic in_fire = 1'b0;

  gzcp_pkg::phase_e gz_phase;
  int          hdr_idx;
  logic [4:0]  byte_count;
  logic [16:0] extra_left;
  logic [7:0]  flg_q;
  logic [31:0] mtime_q;
  logic [2:0]  err_q;
  logic [7:0]  tail [gzcp_pkg::TRAILER_BYTES];
  int          tail_cnt;

  gzip_container_parser_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic gzcp_pkg::phase_e field_after(input logic [7:0] flg, input int stage);
    if (stage <= FROM_XLEN && flg[gzcp_pkg::FLG_EXTRA_BIT]) return gzcp_pkg::PH_XLEN;
    if (stage <= FROM_NAME && flg[gzcp_pkg::FLG_NAME_BIT]) return gzcp_pkg::PH_NAME;
    if (stage <= FROM_COMMENT && flg[gzcp_pkg::FLG_COMMENT_BIT]) return gzcp_pkg::PH_COMMENT;
    if (stage <= FROM_HCRC && flg[gzcp_pkg::FLG_HCRC_BIT]) return gzcp_pkg::PH_HCRC;
    return gzcp_pkg::PH_DATA;
  endfunction

  task automatic clear_parse();
    gz_phase = gzcp_pkg::PH_FIXED;
    hdr_idx = 0;
    byte_count = '0;
    extra_left = '0;
    flg_q = '0;
    mtime_q = '0;
    err_q = gzcp_pkg::ST_OK;
    tail_cnt = 0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    gz_result_t made[$];
    gz_result_t r;
    logic [2:0] bad;
    logic [2:0] st;
    if (byte_count < gzcp_pkg::MIN_MEMBER) byte_count++;
    case (gz_phase)
      gzcp_pkg::PH_FIXED: begin
        bad = gzcp_pkg::ST_OK;
        if (hdr_idx == 0 && b != gzcp_pkg::MAGIC0) bad = gzcp_pkg::ST_BAD_MAGIC;
        if (hdr_idx == 1 && b != gzcp_pkg::MAGIC1) bad = gzcp_pkg::ST_BAD_MAGIC;
        if (hdr_idx == 2 && b != gzcp_pkg::CM_DEFLATE) bad = gzcp_pkg::ST_BAD_METHOD;
        if (bad != gzcp_pkg::ST_OK) begin
          err_q = bad;
          gz_phase = gzcp_pkg::PH_ERROR;
        end else begin
          if (hdr_idx == 3) flg_q = b;
          if (hdr_idx >= 4 && hdr_idx <= 7) mtime_q[8 * (hdr_idx - 4) +: 8] = b;
          if (hdr_idx == 9) begin
            hdr_idx = 0;
            gz_phase = field_after(flg_q, FROM_XLEN);
          end else begin
            hdr_idx++;
          end
        end
      end
      gzcp_pkg::PH_XLEN: begin
        if (hdr_idx == 0) begin
          extra_left = {9'd0, b};
          hdr_idx = 1;
        end else begin
          extra_left[15:8] = b;
          hdr_idx = 0;
          gz_phase = (extra_left != 0) ? gzcp_pkg::PH_EXTRA : field_after(flg_q, FROM_NAME);
        end
      end
      gzcp_pkg::PH_EXTRA: begin
        extra_left--;
        if (extra_left == 0) gz_phase = field_after(flg_q, FROM_NAME);
      end
      gzcp_pkg::PH_NAME: begin
        if (b == 8'h00) begin
          gz_phase = field_after(flg_q, FROM_COMMENT);
        end else begin
          r = '0;
          r.kind = gzcp_pkg::KIND_NAME;
          r.value = b;
          made.insert(made.size(), r);
        end
      end
      gzcp_pkg::PH_COMMENT: begin
        if (b == 8'h00) gz_phase = field_after(flg_q, FROM_HCRC);
      end
      gzcp_pkg::PH_HCRC: begin
        if (hdr_idx == 0) begin
          hdr_idx = 1;
        end else begin
          hdr_idx = 0;
          gz_phase = gzcp_pkg::PH_DATA;
        end
      end
      gzcp_pkg::PH_DATA: begin
        if (tail_cnt >= gzcp_pkg::TRAILER_BYTES) begin
          r = '0;
          r.kind = gzcp_pkg::KIND_PAYLOAD;
          r.value = tail[0];
          made.insert(made.size(), r);
          for (int i = 0; i < gzcp_pkg::TRAILER_BYTES - 1; i++) tail[i] = tail[i + 1];
          tail[gzcp_pkg::TRAILER_BYTES - 1] = b;
        end else begin
          tail[tail_cnt] = b;
          tail_cnt++;
        end
      end
      default: begin
      end
    endcase
    if (lst) begin
      if (byte_count < gzcp_pkg::MIN_MEMBER) st = gzcp_pkg::ST_SHORT;
      else if (err_q != gzcp_pkg::ST_OK) st = err_q;
      else if (gz_phase == gzcp_pkg::PH_XLEN || gz_phase == gzcp_pkg::PH_EXTRA)
        st = gzcp_pkg::ST_TRUNC_EXTRA;
      else if (gz_phase == gzcp_pkg::PH_NAME) st = gzcp_pkg::ST_TRUNC_NAME;
      else if (gz_phase == gzcp_pkg::PH_COMMENT) st = gzcp_pkg::ST_TRUNC_COMMENT;
      else if (gz_phase == gzcp_pkg::PH_DATA && tail_cnt >= gzcp_pkg::TRAILER_BYTES)
        st = gzcp_pkg::ST_OK;
      else st = gzcp_pkg::ST_TRUNC_DATA;
      r = '0;
      r.kind = gzcp_pkg::KIND_SUMMARY;
      r.status = st;
      r.flags = flg_q;
      r.mtime = mtime_q;
      if (st == gzcp_pkg::ST_OK) begin
        r.crc = {tail[3], tail[2], tail[1], tail[0]};
        r.size = {tail[7], tail[6], tail[5], tail[4]};
      end
      made.insert(made.size(), r);
      clear_parse();
    end
    if (made.size() > 0) made[made.size() - 1].run_end = 1'b1;
    foreach (made[i]) expected_beats.insert(expected_beats.size(), made[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_member(input logic [7:0] flg, input int xlen, input int name_len,
                            input int cmt_len, input int body_len, input int cut,
                            input int spoil);
    logic [7:0] mem[$];
    in_beat_t ib;
    int n;
    mem.insert(mem.size(), spoil == SPOIL_MAGIC0 ?
               gzcp_pkg::MAGIC0 ^ 8'($urandom_range(1, 255)) : gzcp_pkg::MAGIC0);
    mem.insert(mem.size(), spoil == SPOIL_MAGIC1 ?
               gzcp_pkg::MAGIC1 ^ 8'($urandom_range(1, 255)) : gzcp_pkg::MAGIC1);
    mem.insert(mem.size(), spoil == SPOIL_METHOD ?
               gzcp_pkg::CM_DEFLATE ^ 8'($urandom_range(1, 255)) : gzcp_pkg::CM_DEFLATE);
    mem.insert(mem.size(), flg);
    repeat (6) mem.insert(mem.size(), 8'($urandom));
    if (flg[gzcp_pkg::FLG_EXTRA_BIT]) begin
      mem.insert(mem.size(), xlen[7:0]);
      mem.insert(mem.size(), xlen[15:8]);
      repeat (xlen) mem.insert(mem.size(), 8'($urandom));
    end
    if (flg[gzcp_pkg::FLG_NAME_BIT]) begin
      repeat (name_len) mem.insert(mem.size(), 8'($urandom_range(1, 255)));
      mem.insert(mem.size(), 8'h00);
    end
    if (flg[gzcp_pkg::FLG_COMMENT_BIT]) begin
      repeat (cmt_len) mem.insert(mem.size(), 8'($urandom_range(1, 255)));
      mem.insert(mem.size(), 8'h00);
    end
    if (flg[gzcp_pkg::FLG_HCRC_BIT]) repeat (2) mem.insert(mem.size(), 8'($urandom));
    repeat (body_len + gzcp_pkg::TRAILER_BYTES) mem.insert(mem.size(), 8'($urandom));
    n = (cut > 0 && cut < mem.size()) ? cut : mem.size();
    for (int i = 0; i < n; i++) begin
      ib.data = mem[i];
      ib.last = (i == n - 1);
      member_bytes_q.insert(member_bytes_q.size(), ib);
    end
    items_queued += n;
  endtask

  task automatic add_noise(input int len);
    in_beat_t ib;
    for (int i = 0; i < len; i++) begin
      ib.data = 8'($urandom);
      ib.last = (i == len - 1);
      member_bytes_q.insert(member_bytes_q.size(), ib);
    end
    items_queued += len;
  endtask

  task automatic random_traffic(input int goal);
    int stop_at;
    int xlen;
    int spoil;
    int cut;
    stop_at = items_queued + goal;
    while (items_queued < stop_at) begin
      if ($urandom_range(99) < 8) begin
        add_noise($urandom_range(1, 24));
      end else begin
        xlen = ($urandom_range(99) < 3) ? $urandom_range(256, 300) : $urandom_range(0, 6);
        spoil = ($urandom_range(99) < 6) ? $urandom_range(SPOIL_MAGIC0, SPOIL_METHOD) : SPOIL_NONE;
        cut = ($urandom_range(99) < 15) ? $urandom_range(1, 40) : 0;
        add_member(8'($urandom), xlen, $urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 24), cut, spoil);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (beats_taken != items_queued || expected_beats.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    in_beat_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (member_bytes_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        beat = member_bytes_q.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= beat.data;
        last_i <= beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    gz_result_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        beats_taken++;
        parse_byte(data_byte_i, last_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, kind %0h byte %0h status %0h",
                   $time, kind_o, out_byte_o, status_o);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("out_byte", want.value, out_byte_o);
          check_field("status", want.status, status_o);
          check_field("header_flags", want.flags, header_flags_o);
          check_field("mod_time", want.mtime, mod_time_o);
          check_field("stored_crc", want.crc, stored_crc_o);
          check_field("stored_size", want.size, stored_size_o);
          check_field("run_end", want.run_end, run_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gzip_container_parser_unit regression: fail");
      $finish;
    end
  end

  initial begin
    clear_parse();
    sender_idle_pct = 13;
    recv_idle_pct = 68;
    add_member(8'h00, 0, 0, 0, 0, 0, SPOIL_NONE);
    add_member(8'h00, 0, 0, 0, 5, 0, SPOIL_NONE);
    add_member(8'h00, 0, 0, 0, 0, 1, SPOIL_NONE);
    add_member(8'h00, 0, 0, 0, 0, 17, SPOIL_NONE);
    add_member(8'h00, 0, 0, 0, 4, 0, SPOIL_MAGIC0);
    add_member(8'h00, 0, 0, 0, 4, 0, SPOIL_MAGIC1);
    add_member(8'h00, 0, 0, 0, 4, 0, SPOIL_METHOD);
    add_member(8'h00, 0, 0, 0, 4, 5, SPOIL_METHOD);
    add_member(8'h04, 0, 0, 0, 3, 0, SPOIL_NONE);
    add_member(8'h04, 257, 0, 0, 2, 0, SPOIL_NONE);
    add_member(8'h04, 20, 0, 0, 0, 25, SPOIL_NONE);
    add_member(8'h08, 0, 12, 0, 0, 18, SPOIL_NONE);
    add_member(8'h18, 0, 10, 3, 0, 21, SPOIL_NONE);
    add_member(8'h10, 0, 0, 15, 0, 20, SPOIL_NONE);
    add_member(8'h12, 0, 0, 8, 0, 20, SPOIL_NONE);
    add_member(8'h08, 0, 8, 0, 0, 22, SPOIL_NONE);
    add_member(8'hFF, 3, 4, 4, 6, 0, SPOIL_NONE);
    add_member(8'hFF, 2, 3, 3, 10, 30, SPOIL_NONE);
    add_member(8'hE1, 0, 0, 0, 3, 0, SPOIL_NONE);
    add_noise(1);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    random_traffic(PHASE_BEATS);
    wait_drained();

    sender_idle_pct = 68;
    recv_idle_pct = 13;
    random_traffic(PHASE_BEATS);
    wait_drained();

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ticket++;
    random_traffic(PRESSURE_BEATS);
    wait_drained();
    random_traffic(PHASE_BEATS);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("gzip_container_parser_unit regression: pass");
    end else begin
      $display("gzip_container_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gzcp_pkg.sv
rtl/gzcp_front.sv
rtl/gzcp_queue.sv
rtl/gzcp_back.sv
rtl/gzip_container_parser_unit.sv
rtl/gzcp_checker.sv
verif/tb.sv
